### sv/two_button_menu_controller_unit_macros.svh
// assertion macros for the two-button menu controller checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TWO_BUTTON_MENU_CONTROLLER_UNIT_MACROS_SVH
`define TWO_BUTTON_MENU_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define TBMC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbmc check failed");

// next-cycle implication, masked during reset
`define TBMC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbmc check failed");

`endif

### sv/tbmc_pkg.sv
// types and constants for the two-button menu controller
// no dependencies; used by the channel interfaces, the top level and the checker
package tbmc_pkg;

  typedef logic [31:0]        stamp_t;
  typedef logic [15:0]        ms16_t;
  typedef logic [15:0]        setpt_t;
  typedef logic signed [6:0]  cal_t;
  typedef logic [1:0]         page_t;
  typedef logic [1:0]         mask_t;
  typedef logic [2:0]         cfg_idx_t;
  typedef logic [15:0]        cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_PUMP_HOLD   = 3'd0;
  localparam cfg_idx_t REG_PAGE_HOLD   = 3'd1;
  localparam cfg_idx_t REG_DEBOUNCE    = 3'd2;
  localparam cfg_idx_t REG_UP_HOLD     = 3'd3;
  localparam cfg_idx_t REG_INIT_SETPT  = 3'd4;
  localparam cfg_idx_t REG_INIT_CAL    = 3'd5;
  localparam cfg_idx_t REG_INIT_PUMP   = 3'd6;
  localparam cfg_idx_t REG_INIT_SYSTEM = 3'd7;

  // reset values
  localparam ms16_t  PUMP_HOLD_RST = 16'd2000;
  localparam ms16_t  PAGE_HOLD_RST = 16'd300;
  localparam ms16_t  DEBOUNCE_RST  = 16'd50;
  localparam ms16_t  UP_HOLD_RST   = 16'd1000;
  localparam setpt_t SETPT_RST     = 16'd0;
  localparam cal_t   CAL_RST       = 7'sd0;

  // pages
  localparam page_t PAGE_SETPOINT = 2'd0;
  localparam page_t PAGE_MEASURE  = 2'd1;
  localparam page_t PAGE_CAL      = 2'd2;
  localparam page_t PAGE_CALIBRATE = 2'd3;

  // button masks, bit 0 up, bit 1 down
  localparam mask_t MASK_NONE = 2'd0;
  localparam mask_t MASK_UP   = 2'd1;
  localparam mask_t MASK_DOWN = 2'd2;
  localparam mask_t MASK_BOTH = 2'd3;

  // value limits
  localparam setpt_t SET_MAX  = 16'd65000;
  localparam setpt_t SET_STEP = 16'd10;
  localparam cal_t   CAL_MAX  = 7'sd50;
  localparam cal_t   CAL_MIN  = -7'sd50;

endpackage

### sv/tbmc_if.sv
// valid/ready channel interfaces: button poll input, menu result output, register writes
// depends on tbmc_pkg
interface tbmc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 up_pressed;
  logic                 down_pressed;
  tbmc_pkg::stamp_t     time_ms;
  logic                 calib_busy;

  modport source (output valid, output up_pressed, output down_pressed,
                  output time_ms, output calib_busy, input ready);
  modport sink   (input valid, input up_pressed, input down_pressed,
                  input time_ms, input calib_busy, output ready);
endinterface

interface tbmc_out_if;
  logic                 valid;
  logic                 ready;
  tbmc_pkg::page_t      page;
  logic                 page_changed;
  logic                 pump_on;
  logic                 system_on;
  tbmc_pkg::setpt_t     setpoint_value;
  tbmc_pkg::cal_t       cal_value;
  logic                 calib_start;

  modport source (output valid, output page, output page_changed, output pump_on,
                  output system_on, output setpoint_value, output cal_value,
                  output calib_start, input ready);
  modport sink   (input valid, input page, input page_changed, input pump_on,
                  input system_on, input setpoint_value, input cal_value,
                  input calib_start, output ready);
endinterface

interface tbmc_cfg_if;
  logic                 valid;
  logic                 ready;
  tbmc_pkg::cfg_idx_t   index;
  tbmc_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/two_button_menu_controller_unit.sv
// two-button menu controller: page, pump, system, setpoint and cal scalar from button polls
// depends on tbmc_pkg and the channel interfaces in tbmc_if.sv
//
// One poll item is taken per clock while the input is not stalled. An accepted item sits in an
// input register, passes through a single pass of compares and 32-bit timestamp subtractions
// that also updates the menu state unless calib_busy is set, and its result is loaded into the
// output register. The state is updated in the same edge that loads the result, so the next item
// sees it at once; the input only stalls when the input register is full and the output register
// is full and not being taken. Register writes are accepted in every cycle and must be made while
// idle. Writing an initial value register also loads it into the live state.
module two_button_menu_controller_unit (
  input  logic         clk,
  input  logic         rst_n,
  tbmc_in_if.sink      in_chan,
  tbmc_out_if.source   out_chan,
  tbmc_cfg_if.sink     cfg_chan
);

  // configuration
  tbmc_pkg::ms16_t  pump_hold_r, page_hold_r, debounce_r, up_hold_r;

  // menu state
  logic             dual_active_r, dual_active_nxt;
  tbmc_pkg::stamp_t dual_start_r, dual_start_nxt;
  logic             latched_r, latched_nxt;
  tbmc_pkg::mask_t  prev_mask_r;
  tbmc_pkg::stamp_t last_db_r, last_db_nxt;
  tbmc_pkg::stamp_t up_start_r, up_start_nxt;
  tbmc_pkg::page_t  page_r, page_nxt;
  tbmc_pkg::setpt_t setpt_r, setpt_nxt;
  tbmc_pkg::cal_t   cal_r, cal_nxt;
  logic             pump_r, pump_nxt;
  logic             system_r, system_nxt;
  logic             changed_nxt, cal_start_nxt;
  tbmc_pkg::mask_t  prev_eff;

  // input register
  logic             s1_valid_r;
  logic             s1_up_r, s1_dn_r, s1_busy_r;
  tbmc_pkg::stamp_t s1_time_r;

  // output register
  logic             out_valid_r;
  tbmc_pkg::page_t  out_page_r;
  logic             out_changed_r, out_pump_r, out_system_r, out_cal_start_r;
  tbmc_pkg::setpt_t out_setpt_r;
  tbmc_pkg::cal_t   out_cal_r;

  logic             out_free, fire, in_take;
  tbmc_pkg::mask_t  mask;
  tbmc_pkg::stamp_t dual_el, held_el, db_el, up_el;

  assign out_free         = !out_valid_r || out_chan.ready;
  assign fire             = s1_valid_r && out_free;
  assign in_chan.ready    = !s1_valid_r || out_free;
  assign in_take          = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready   = 1'b1;

  assign mask    = {s1_dn_r, s1_up_r};
  assign dual_el = dual_active_r ? (s1_time_r - dual_start_r) : '0;
  assign held_el = s1_time_r - dual_start_r;
  assign db_el   = s1_time_r - last_db_r;
  assign up_el   = s1_time_r - up_start_r;

  always_comb begin
    dual_active_nxt = dual_active_r;
    dual_start_nxt  = dual_start_r;
    latched_nxt     = latched_r;
    last_db_nxt     = last_db_r;
    up_start_nxt    = up_start_r;
    page_nxt        = page_r;
    setpt_nxt       = setpt_r;
    cal_nxt         = cal_r;
    pump_nxt        = pump_r;
    system_nxt      = system_r;
    changed_nxt     = 1'b0;
    cal_start_nxt   = 1'b0;
    prev_eff        = prev_mask_r;

    // dual press: hold action or page cycle on release
    if (mask == tbmc_pkg::MASK_BOTH) begin
      if (!dual_active_r) begin
        dual_active_nxt = 1'b1;
        dual_start_nxt  = s1_time_r;
        latched_nxt     = 1'b0;
      end
      if (!latched_nxt && dual_el >= {16'd0, pump_hold_r}) begin
        latched_nxt = 1'b1;
        if (page_r == tbmc_pkg::PAGE_CALIBRATE) begin
          cal_start_nxt   = 1'b1;
          page_nxt        = tbmc_pkg::PAGE_SETPOINT;
          changed_nxt     = 1'b1;
          dual_active_nxt = 1'b0;
          latched_nxt     = 1'b0;
          prev_eff        = tbmc_pkg::MASK_NONE;
        end else begin
          pump_nxt = !pump_r;
        end
      end
    end else if (dual_active_r) begin
      if (!latched_r && held_el >= {16'd0, page_hold_r} && held_el < {16'd0, pump_hold_r}) begin
        page_nxt    = page_r + 2'd1;
        changed_nxt = 1'b1;
      end
      dual_active_nxt = 1'b0;
    end

    // debounced single releases
    if (mask != prev_eff && db_el > {16'd0, debounce_r}) begin
      if (prev_eff == tbmc_pkg::MASK_UP && mask == tbmc_pkg::MASK_NONE) begin
        if (page_nxt == tbmc_pkg::PAGE_SETPOINT &&
            setpt_r <= tbmc_pkg::SET_MAX - tbmc_pkg::SET_STEP)
          setpt_nxt = setpt_r + tbmc_pkg::SET_STEP;
        if (page_nxt == tbmc_pkg::PAGE_CAL && cal_r < tbmc_pkg::CAL_MAX)
          cal_nxt = cal_r + 7'sd1;
      end
      if (prev_eff == tbmc_pkg::MASK_DOWN && mask == tbmc_pkg::MASK_NONE) begin
        if (page_nxt == tbmc_pkg::PAGE_SETPOINT && setpt_r >= tbmc_pkg::SET_STEP)
          setpt_nxt = setpt_r - tbmc_pkg::SET_STEP;
        if (page_nxt == tbmc_pkg::PAGE_CAL && cal_r > tbmc_pkg::CAL_MIN)
          cal_nxt = cal_r - 7'sd1;
      end
      last_db_nxt = s1_time_r;
    end

    // long hold of up alone, zero start means not holding
    if (mask == tbmc_pkg::MASK_UP) begin
      if (up_start_r == '0) begin
        up_start_nxt = s1_time_r;
      end else if (up_el >= {16'd0, up_hold_r}) begin
        system_nxt   = !system_r;
        up_start_nxt = '0;
      end
    end else begin
      up_start_nxt = '0;
    end

    if (s1_busy_r) begin
      dual_active_nxt = dual_active_r;
      dual_start_nxt  = dual_start_r;
      latched_nxt     = latched_r;
      last_db_nxt     = last_db_r;
      up_start_nxt    = up_start_r;
      page_nxt        = page_r;
      setpt_nxt       = setpt_r;
      cal_nxt         = cal_r;
      pump_nxt        = pump_r;
      system_nxt      = system_r;
      changed_nxt     = 1'b0;
      cal_start_nxt   = 1'b0;
    end
  end

  // configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_hold_r   <= tbmc_pkg::PUMP_HOLD_RST;
      page_hold_r   <= tbmc_pkg::PAGE_HOLD_RST;
      debounce_r    <= tbmc_pkg::DEBOUNCE_RST;
      up_hold_r     <= tbmc_pkg::UP_HOLD_RST;
      dual_active_r <= 1'b0;
      dual_start_r  <= '0;
      latched_r     <= 1'b0;
      prev_mask_r   <= tbmc_pkg::MASK_NONE;
      last_db_r     <= '0;
      up_start_r    <= '0;
      page_r        <= tbmc_pkg::PAGE_SETPOINT;
      setpt_r       <= tbmc_pkg::SETPT_RST;
      cal_r         <= tbmc_pkg::CAL_RST;
      pump_r        <= 1'b0;
      system_r      <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        tbmc_pkg::REG_PUMP_HOLD:   pump_hold_r <= cfg_chan.data;
        tbmc_pkg::REG_PAGE_HOLD:   page_hold_r <= cfg_chan.data;
        tbmc_pkg::REG_DEBOUNCE:    debounce_r  <= cfg_chan.data;
        tbmc_pkg::REG_UP_HOLD:     up_hold_r   <= cfg_chan.data;
        tbmc_pkg::REG_INIT_SETPT:  setpt_r     <= cfg_chan.data;
        tbmc_pkg::REG_INIT_CAL:    cal_r       <= tbmc_pkg::cal_t'(cfg_chan.data[6:0]);
        tbmc_pkg::REG_INIT_PUMP:   pump_r      <= cfg_chan.data[0];
        tbmc_pkg::REG_INIT_SYSTEM: system_r    <= cfg_chan.data[0];
        default: ;
      endcase
    end else if (fire && !s1_busy_r) begin
      dual_active_r <= dual_active_nxt;
      dual_start_r  <= dual_start_nxt;
      latched_r     <= latched_nxt;
      prev_mask_r   <= mask;
      last_db_r     <= last_db_nxt;
      up_start_r    <= up_start_nxt;
      page_r        <= page_nxt;
      setpt_r       <= setpt_nxt;
      cal_r         <= cal_nxt;
      pump_r        <= pump_nxt;
      system_r      <= system_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_up_r   <= in_chan.up_pressed;
      s1_dn_r   <= in_chan.down_pressed;
      s1_time_r <= in_chan.time_ms;
      s1_busy_r <= in_chan.calib_busy;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_page_r      <= page_nxt;
      out_changed_r   <= changed_nxt;
      out_pump_r      <= pump_nxt;
      out_system_r    <= system_nxt;
      out_setpt_r     <= setpt_nxt;
      out_cal_r       <= cal_nxt;
      out_cal_start_r <= cal_start_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.page           = out_page_r;
  assign out_chan.page_changed   = out_changed_r;
  assign out_chan.pump_on        = out_pump_r;
  assign out_chan.system_on      = out_system_r;
  assign out_chan.setpoint_value = out_setpt_r;
  assign out_chan.cal_value      = out_cal_r;
  assign out_chan.calib_start    = out_cal_start_r;

endmodule

### sv/tbmc_checker.sv
// port-level checks for the two-button menu controller, bound to the top level
// depends on tbmc_pkg, the channel interfaces and the assertion macro header
`include "two_button_menu_controller_unit_macros.svh"

module tbmc_checker (
  input  logic        clk,
  input  logic        rst_n,
  tbmc_in_if.sink     in_chan,
  tbmc_out_if.source  out_chan
);

  logic calib_pulse, home_shown;

  assign calib_pulse = out_chan.valid && out_chan.calib_start;
  assign home_shown  = out_chan.page == tbmc_pkg::PAGE_SETPOINT && out_chan.page_changed;

  `TBMC_ASSERT_NXT(a_out_hold, out_chan.valid && !out_chan.ready, out_chan.valid)
  `TBMC_ASSERT_IMP(a_stall_only_when_full, !in_chan.ready, out_chan.valid)
  `TBMC_ASSERT_IMP(a_calib_returns_home, calib_pulse, home_shown)

endmodule

bind two_button_menu_controller_unit tbmc_checker u_tbmc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
